// ===== sv/dpts_pkg.sv =====
// Package for the dynamic priority task scheduler.
// Holds the shared widths, command codes, FSM state type and the structs
// that travel between the top level and the row of task cells.
`timescale 1ns / 1ps

package dpts_pkg;

    // Default table depth
    localparam int MAX_TASKS_DEF = 16;

    // Fixed field widths
    localparam int DATA_W = 16;

    // Command codes
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Priority limits
    localparam logic signed [DATA_W-1:0] PRIO_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] PRIO_MIN = 16'sh8000;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AGE,
        ST_SCAN,
        ST_COMMIT
    } state_t;

    // Contents of one table slot, handed to the lower neighbor on removal
    typedef struct packed {
        logic                     valid;
        logic                     running;
        logic [DATA_W-1:0]        id;
        logic [DATA_W-1:0]        length;
        logic [DATA_W-1:0]        progress;
        logic signed [DATA_W-1:0] prio;
    } slot_t;

    // Best-candidate token that walks down the row during the scan
    typedef struct packed {
        logic                     has;
        logic signed [DATA_W-1:0] prio;
        logic [DATA_W-1:0]        id;
        logic [DATA_W-1:0]        progress;
        logic                     done;
    } tok_t;

    // Commands broadcast from the controller to every cell
    typedef struct packed {
        logic age;
        logic add;
        logic run;
        logic run_done;
    } cell_ctrl_t;

endpackage

// ===== sv/dpts_if.sv =====
// Request and response channel interfaces for the task scheduler.
// Depends on dpts_pkg for the field widths.
`timescale 1ns / 1ps

interface dpts_in_if;
    logic                              valid;
    logic                              ready;
    logic                              command;
    logic [dpts_pkg::DATA_W-1:0]       task_length;
    logic signed [dpts_pkg::DATA_W-1:0] task_priority;

    modport source (output valid, output command, output task_length,
                    output task_priority, input ready);
    modport sink   (input valid, input command, input task_length,
                    input task_priority, output ready);
endinterface

interface dpts_out_if;
    logic                        valid;
    logic                        ready;
    logic                        ran_valid;
    logic [dpts_pkg::DATA_W-1:0] ran_id;
    logic [dpts_pkg::DATA_W-1:0] ran_progress;
    logic                        ran_finished;
    logic                        add_accepted;
    logic [dpts_pkg::DATA_W-1:0] assigned_id;

    modport source (output valid, output ran_valid, output ran_id,
                    output ran_progress, output ran_finished,
                    output add_accepted, output assigned_id, input ready);
    modport sink   (input valid, input ran_valid, input ran_id,
                    input ran_progress, input ran_finished,
                    input add_accepted, input assigned_id, output ready);
endinterface

// ===== sv/dpts_cell.sv =====
// One task slot of the scheduler table: holds a task, ages its priority,
// folds itself into the best-candidate token and shifts on removal.
// Depends on dpts_pkg.
`timescale 1ns / 1ps

module dpts_cell #(
    parameter int MAX_TASKS = dpts_pkg::MAX_TASKS_DEF,
    parameter int IDX       = 0
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dpts_pkg::cell_ctrl_t                ctrl,
    input  logic [$clog2(MAX_TASKS)-1:0]        pick_idx,
    input  logic [dpts_pkg::DATA_W-1:0]         add_length,
    input  logic signed [dpts_pkg::DATA_W-1:0]  add_prio,
    input  logic [dpts_pkg::DATA_W-1:0]         add_id,
    input  logic                                prev_valid,
    input  dpts_pkg::slot_t                     next_slot,
    input  dpts_pkg::tok_t                      tok_in,
    input  logic [$clog2(MAX_TASKS)-1:0]        tok_in_idx,
    output dpts_pkg::slot_t                     slot,
    output dpts_pkg::tok_t                      tok_out,
    output logic [$clog2(MAX_TASKS)-1:0]        tok_out_idx
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic                               valid_reg, valid_next;
    logic                               running_reg, running_next;
    logic [dpts_pkg::DATA_W-1:0]        id_reg, id_next;
    logic [dpts_pkg::DATA_W-1:0]        len_reg, len_next;
    logic [dpts_pkg::DATA_W-1:0]        prog_reg, prog_next;
    logic signed [dpts_pkg::DATA_W-1:0] prio_reg, prio_next;
    dpts_pkg::tok_t                     tok_reg, tok_next;
    logic [IDX_W-1:0]                   tok_idx_reg, tok_idx_next;
    logic [dpts_pkg::DATA_W-1:0]        prog_inc;
    logic                               take_own;

    assign prog_inc = prog_reg + dpts_pkg::DATA_W'(1);

    // Slot update: aging, append, run and compaction
    always_comb
    begin
        valid_next   = valid_reg;
        running_next = running_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        prog_next    = prog_reg;
        prio_next    = prio_reg;

        if (ctrl.age && valid_reg)
        begin
            if (running_reg)
            begin
                if (prio_reg != dpts_pkg::PRIO_MIN)
                    prio_next = prio_reg - dpts_pkg::DATA_W'(1);
            end
            else
            begin
                if (prio_reg != dpts_pkg::PRIO_MAX)
                    prio_next = prio_reg + dpts_pkg::DATA_W'(1);
            end
        end

        if (ctrl.add && !valid_reg && prev_valid)
        begin
            valid_next   = 1'b1;
            running_next = 1'b0;
            id_next      = add_id;
            len_next     = add_length;
            prog_next    = '0;
            prio_next    = add_prio;
        end

        if (ctrl.run)
        begin
            if (ctrl.run_done && (pick_idx <= MY_IDX))
            begin
                // finished task leaves; upper neighbor moves down
                valid_next   = next_slot.valid;
                running_next = 1'b0;
                id_next      = next_slot.id;
                len_next     = next_slot.length;
                prog_next    = next_slot.progress;
                prio_next    = next_slot.prio;
            end
            else if (pick_idx == MY_IDX)
            begin
                prog_next    = prog_inc;
                running_next = 1'b1;
            end
            else
            begin
                running_next = 1'b0;
            end
        end
    end

    // Fold this slot into the token; strict compare keeps the later task on ties
    assign take_own = valid_reg && (!tok_in.has || (prio_reg > tok_in.prio));

    always_comb
    begin
        tok_next     = tok_in;
        tok_idx_next = tok_in_idx;
        if (take_own)
        begin
            tok_next.has      = 1'b1;
            tok_next.prio     = prio_reg;
            tok_next.id       = id_reg;
            tok_next.progress = prog_inc;
            tok_next.done     = (prog_inc == len_reg);
            tok_idx_next      = MY_IDX;
        end
    end

    // Control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            running_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            running_reg <= running_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        id_reg      <= id_next;
        len_reg     <= len_next;
        prog_reg    <= prog_next;
        prio_reg    <= prio_next;
        tok_reg     <= tok_next;
        tok_idx_reg <= tok_idx_next;
    end

    assign slot.valid    = valid_reg;
    assign slot.running  = running_reg;
    assign slot.id       = id_reg;
    assign slot.length   = len_reg;
    assign slot.progress = prog_reg;
    assign slot.prio     = prio_reg;
    assign tok_out       = tok_reg;
    assign tok_out_idx   = tok_idx_reg;

endmodule

// ===== sv/dynamic_priority_task_scheduler_unit.sv =====
// Dynamic priority task scheduler with aging, top level.
// Add: the request is registered and the commit state loads the response register.
// Tick: aging state, scan while the token walks one cell per cycle down the row, commit.
// One request at a time: a new one is taken only in idle, after the commit, which waits
// while a response waits. Reset (async, rst_n low) empties the table, next id is 1.
// Depends on dpts_pkg, dpts_if and dpts_cell.
`timescale 1ns / 1ps

module dynamic_priority_task_scheduler_unit #(
    parameter int MAX_TASKS = dpts_pkg::MAX_TASKS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    dpts_in_if.sink         req,
    dpts_out_if.source      rsp
);

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int DW    = dpts_pkg::DATA_W;

    dpts_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] scan_cnt_reg, scan_cnt_next;
    logic [DW-1:0]    next_id_reg, next_id_next;

    logic                 cmd_reg;
    logic [DW-1:0]        len_reg;
    logic signed [DW-1:0] prio_reg;

    logic          out_valid_reg, out_valid_next;
    logic          ran_valid_reg, ran_valid_next;
    logic [DW-1:0] ran_id_reg, ran_id_next;
    logic [DW-1:0] ran_prog_reg, ran_prog_next;
    logic          ran_fin_reg, ran_fin_next;
    logic          add_acc_reg, add_acc_next;
    logic [DW-1:0] asg_id_reg, asg_id_next;

    logic                 accept;
    logic                 commit_go;
    logic                 add_ok;
    logic                 run_ok;
    dpts_pkg::cell_ctrl_t ctrl;

    dpts_pkg::slot_t  slots    [MAX_TASKS];
    dpts_pkg::tok_t   toks     [MAX_TASKS];
    logic [IDX_W-1:0] tok_idxs [MAX_TASKS];
    logic [MAX_TASKS-1:0] valid_vec;
    logic [MAX_TASKS-1:0] running_vec;

    dpts_pkg::slot_t  empty_slot;
    dpts_pkg::tok_t   seed_tok;

    assign empty_slot = '0;
    assign seed_tok   = '0;

    assign accept    = req.valid && req.ready;
    assign commit_go = (state_reg == dpts_pkg::ST_COMMIT) && (!out_valid_reg || rsp.ready);
    assign add_ok    = (cmd_reg == dpts_pkg::CMD_ADD) && (len_reg != '0)
                       && !valid_vec[MAX_TASKS-1];
    assign run_ok    = (cmd_reg == dpts_pkg::CMD_TICK) && valid_vec[0];

    // Broadcast commands to the cells
    assign ctrl.age      = (state_reg == dpts_pkg::ST_AGE);
    assign ctrl.add      = commit_go && add_ok;
    assign ctrl.run      = commit_go && run_ok;
    assign ctrl.run_done = toks[0].done;

    // Row of task cells; token enters at the top and walks down to cell 0
    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        dpts_cell #(
            .MAX_TASKS (MAX_TASKS),
            .IDX       (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .pick_idx    (tok_idxs[0]),
            .add_length  (len_reg),
            .add_prio    (prio_reg),
            .add_id      (next_id_reg),
            .prev_valid  ((k == 0) ? 1'b1 : slots[(k == 0) ? 0 : k-1].valid),
            .next_slot   ((k == MAX_TASKS-1) ? empty_slot
                                             : slots[(k == MAX_TASKS-1) ? k : k+1]),
            .tok_in      ((k == MAX_TASKS-1) ? seed_tok
                                             : toks[(k == MAX_TASKS-1) ? k : k+1]),
            .tok_in_idx  ((k == MAX_TASKS-1) ? '0
                                             : tok_idxs[(k == MAX_TASKS-1) ? k : k+1]),
            .slot        (slots[k]),
            .tok_out     (toks[k]),
            .tok_out_idx (tok_idxs[k])
        );
        assign valid_vec[k]   = slots[k].valid;
        assign running_vec[k] = slots[k].running;
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        scan_cnt_next = scan_cnt_reg;
        case (state_reg)
            dpts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.command == dpts_pkg::CMD_ADD)
                        state_next = dpts_pkg::ST_COMMIT;
                    else
                        state_next = dpts_pkg::ST_AGE;
                end
            end
            dpts_pkg::ST_AGE:
            begin
                scan_cnt_next = '0;
                state_next    = dpts_pkg::ST_SCAN;
            end
            dpts_pkg::ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                if (scan_cnt_reg == IDX_W'(MAX_TASKS - 1))
                    state_next = dpts_pkg::ST_COMMIT;
            end
            dpts_pkg::ST_COMMIT:
            begin
                if (commit_go)
                    state_next = dpts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dpts_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and response register
    always_comb
    begin
        req.ready      = (state_reg == dpts_pkg::ST_IDLE);
        out_valid_next = out_valid_reg && !rsp.ready;
        ran_valid_next = ran_valid_reg;
        ran_id_next    = ran_id_reg;
        ran_prog_next  = ran_prog_reg;
        ran_fin_next   = ran_fin_reg;
        add_acc_next   = add_acc_reg;
        asg_id_next    = asg_id_reg;
        next_id_next   = next_id_reg;
        if (commit_go)
        begin
            out_valid_next = 1'b1;
            ran_valid_next = run_ok;
            ran_id_next    = run_ok ? toks[0].id : '0;
            ran_prog_next  = run_ok ? toks[0].progress : '0;
            ran_fin_next   = run_ok && toks[0].done;
            add_acc_next   = add_ok;
            asg_id_next    = add_ok ? next_id_reg : '0;
            if (add_ok)
                next_id_next = next_id_reg + DW'(1);
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpts_pkg::ST_IDLE;
            scan_cnt_reg  <= '0;
            next_id_reg   <= DW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Request and response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= req.command;
            len_reg  <= req.task_length;
            prio_reg <= req.task_priority;
        end
        ran_valid_reg <= ran_valid_next;
        ran_id_reg    <= ran_id_next;
        ran_prog_reg  <= ran_prog_next;
        ran_fin_reg   <= ran_fin_next;
        add_acc_reg   <= add_acc_next;
        asg_id_reg    <= asg_id_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.ran_valid    = ran_valid_reg;
    assign rsp.ran_id       = ran_id_reg;
    assign rsp.ran_progress = ran_prog_reg;
    assign rsp.ran_finished = ran_fin_reg;
    assign rsp.add_accepted = add_acc_reg;
    assign rsp.assigned_id  = asg_id_reg;

    // Occupied slots always form a prefix of the table
    assert property (@(posedge clk) disable iff (!rst_n)
        ((valid_vec + MAX_TASKS'(1)) & valid_vec) == '0)
        else $error("task table has a hole");

    // At most one task is marked running
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(running_vec))
        else $error("more than one running task");

    // A response only appears after a commit cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(state_reg == dpts_pkg::ST_COMMIT))
        else $error("response without commit");

    // An accepted request always leaves idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != dpts_pkg::ST_IDLE)
        else $error("request accepted but controller stayed idle");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the dynamic priority task scheduler.
// It predicts every response from its own copy of the task table and checks them in order.
// Depends on dpts_pkg, dpts_if and dynamic_priority_task_scheduler_unit.
`timescale 1ns / 1ps

module tb_top;

    localparam int NTASK           = dpts_pkg::MAX_TASKS_DEF;
    localparam int DW              = dpts_pkg::DATA_W;
    localparam int RANDOM_REQUESTS = 650;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 2 * NTASK + 10;
    localparam int CYCLE_LIMIT     = 500_000;
    localparam int MAX_PRINTS      = 40;
    localparam int HOLD_AFTER      = 60;

    // One entry of the predicted task table
    typedef struct {
        logic [DW-1:0]        id;
        logic [DW-1:0]        length;
        logic [DW-1:0]        progress;
        logic signed [DW-1:0] prio;
        logic                 running;
    } task_entry_t;

    // One response of the block
    typedef struct {
        logic          ran_valid;
        logic [DW-1:0] ran_id;
        logic [DW-1:0] ran_progress;
        logic          ran_finished;
        logic          add_accepted;
        logic [DW-1:0] assigned_id;
    } sched_result_t;

    // Task table predictor plus the queue of responses still owed by the block
    class sched_scoreboard;
        task_entry_t   tasks_q[$];
        sched_result_t pending_results[$];
        logic [DW-1:0] next_id;
        int            depth;
        int            errors;
        int            checked;

        function new(int depth_i);
            depth   = depth_i;
            next_id = 1;
            errors  = 0;
            checked = 0;
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTS)
                $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endtask

        // Apply one accepted request to the table and queue the response it owes
        function void apply_request(logic cmd, logic [DW-1:0] len,
                                    logic signed [DW-1:0] prio);
            sched_result_t r;
            task_entry_t   t;
            int            pick;
            int            level;
            r = '{default: '0};
            if (cmd == dpts_pkg::CMD_ADD)
            begin
                // zero length or a full table: rejected, no id used up
                if (len != 0 && tasks_q.size() < depth)
                begin
                    t.id       = next_id;
                    t.length   = len;
                    t.progress = '0;
                    t.prio     = prio;
                    t.running  = 1'b0;
                    tasks_q.insert(tasks_q.size(), t);
                    r.add_accepted = 1'b1;
                    r.assigned_id  = next_id;
                    next_id        = next_id + 1'b1;
                end
            end
            else if (tasks_q.size() > 0)
            begin
                // age from the newest entry down; strict compare keeps the newest on a tie
                pick = tasks_q.size() - 1;
                for (int i = tasks_q.size() - 1; i >= 0; i--)
                begin
                    level = tasks_q[i].prio;
                    level = tasks_q[i].running ? level - 1 : level + 1;
                    if (level > dpts_pkg::PRIO_MAX)
                        level = dpts_pkg::PRIO_MAX;
                    if (level < dpts_pkg::PRIO_MIN)
                        level = dpts_pkg::PRIO_MIN;
                    tasks_q[i].prio = DW'(level);
                    if (tasks_q[i].prio > tasks_q[pick].prio)
                        pick = i;
                    tasks_q[i].running = 1'b0;
                end
                tasks_q[pick].running  = 1'b1;
                tasks_q[pick].progress = tasks_q[pick].progress + 1'b1;
                r.ran_valid    = 1'b1;
                r.ran_id       = tasks_q[pick].id;
                r.ran_progress = tasks_q[pick].progress;
                r.ran_finished = (tasks_q[pick].progress == tasks_q[pick].length);
                if (r.ran_finished)
                    tasks_q.delete(pick);
            end
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Compare one accepted response with the oldest pending one
        task check_result(sched_result_t got);
            sched_result_t exp;
            if (pending_results.size() == 0)
            begin
                report("response with no request outstanding");
                return;
            end
            exp = pending_results.pop_front();
            if (got.ran_valid !== exp.ran_valid)
                report($sformatf("response %0d: ran_valid %b, want %b",
                                 checked, got.ran_valid, exp.ran_valid));
            if (got.ran_id !== exp.ran_id)
                report($sformatf("response %0d: ran_id %0d, want %0d",
                                 checked, got.ran_id, exp.ran_id));
            if (got.ran_progress !== exp.ran_progress)
                report($sformatf("response %0d: ran_progress %0d, want %0d",
                                 checked, got.ran_progress, exp.ran_progress));
            if (got.ran_finished !== exp.ran_finished)
                report($sformatf("response %0d: ran_finished %b, want %b",
                                 checked, got.ran_finished, exp.ran_finished));
            if (got.add_accepted !== exp.add_accepted)
                report($sformatf("response %0d: add_accepted %b, want %b",
                                 checked, got.add_accepted, exp.add_accepted));
            if (got.assigned_id !== exp.assigned_id)
                report($sformatf("response %0d: assigned_id %0d, want %0d",
                                 checked, got.assigned_id, exp.assigned_id));
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   hold_done;
    int   result_count;
    int   cycle_count;

    sched_scoreboard sb;

    dpts_in_if  req_if ();
    dpts_out_if rsp_if ();

    dynamic_priority_task_scheduler_unit #(
        .MAX_TASKS (NTASK)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // 2 ns clock
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Offer one request, called at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input logic cmd, input logic [DW-1:0] len,
                                input logic signed [DW-1:0] prio);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid         = 1'b1;
        req_if.command       = cmd;
        req_if.task_length   = len;
        req_if.task_priority = prio;
        do
        begin
            @(posedge clk);
        end while (!req_if.ready);
        sb.apply_request(cmd, len, prio);
        @(negedge clk);
    endtask

    // Response sink: random stalls plus one long hold-off to back the block up
    initial
    begin
        int gap;
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!hold_done && result_count >= HOLD_AFTER)
            begin
                rsp_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                rsp_if.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            rsp_if.ready = 1'b1;
        end
    end

    // Response monitor
    always @(posedge clk)
    begin
        sched_result_t got;
        if (rst_n && rsp_if.valid && rsp_if.ready)
        begin
            got.ran_valid    = rsp_if.ran_valid;
            got.ran_id       = rsp_if.ran_id;
            got.ran_progress = rsp_if.ran_progress;
            got.ran_finished = rsp_if.ran_finished;
            got.add_accepted = rsp_if.add_accepted;
            got.assigned_id  = rsp_if.assigned_id;
            sb.check_result(got);
            result_count++;
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    // Stimulus
    initial
    begin
        int            r;
        logic          cmd;
        logic [DW-1:0] len;
        logic [DW-1:0] prio_bits;

        sb           = new(NTASK);
        hold_done    = 1'b0;
        result_count = 0;

        req_if.valid         = 1'b0;
        req_if.command       = dpts_pkg::CMD_ADD;
        req_if.task_length   = '0;
        req_if.task_priority = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty tick, zero length, priority limits, ties, full table
        send_request(dpts_pkg::CMD_TICK, 16'd0, 16'sd0);
        send_request(dpts_pkg::CMD_ADD, 16'd0, 16'sd0);
        send_request(dpts_pkg::CMD_ADD, 16'd1, dpts_pkg::PRIO_MAX);
        send_request(dpts_pkg::CMD_ADD, 16'hFFFF, dpts_pkg::PRIO_MIN);
        // top saturation and finish, then the lone task runs down to the floor
        repeat (4) send_request(dpts_pkg::CMD_TICK, 16'd0, 16'sd0);
        for (int k = 0; k < NTASK - 1; k++)
            send_request(dpts_pkg::CMD_ADD, DW'(1 + k % 3), 16'sd100);
        send_request(dpts_pkg::CMD_ADD, 16'd5, 16'sd0);
        send_request(dpts_pkg::CMD_TICK, 16'd0, 16'sd0);

        // Random mix of adds and ticks
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            cmd = ($urandom_range(0, 99) < 48) ? dpts_pkg::CMD_ADD : dpts_pkg::CMD_TICK;
            r = $urandom_range(0, 99);
            if (r < 2)
                len = DW'($urandom_range(0, 65535));
            else if (r < 7)
                len = '0;
            else if (r < 85)
                len = DW'($urandom_range(1, 4));
            else
                len = DW'($urandom_range(5, 40));
            r = $urandom_range(0, 99);
            if (r < 30)
                prio_bits = DW'($urandom);
            else if (r < 45)
                prio_bits = 16'h7FF8 + DW'($urandom_range(0, 7));
            else if (r < 60)
                prio_bits = 16'h8000 + DW'($urandom_range(0, 7));
            else
                prio_bits = DW'($urandom_range(0, 8)) - 16'd4;
            send_request(cmd, len, prio_bits);
        end
        req_if.valid = 1'b0;

        // Drain and decide
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
